// ===== src/rc4_stream_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// same-cycle implication
`define RC4_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define RC4_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 package
// Shared widths, request kinds and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef struct packed {
        logic capture;
        logic key_load;
        logic sch_start;
        logic init_wr;
        logic sched;
        logic rd_x;
        logic rd_xn;
        logic rd_y;
        logic wr_x;
        logic wr_y;
        logic rd_ks;
        logic sch_done;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_data;
        logic last;
        logic keyed;
        logic x_max;
        logic out_free;
    } t_stat;

endpackage

// ===== src/rc4_ctrl.sv =====
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences key loading, the key schedule and the keystream step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_KEY   = 4'd2;
    localparam logic [3:0] ST_INIT  = 4'd3;
    localparam logic [3:0] ST_S_RDX = 4'd4;
    localparam logic [3:0] ST_S_RDY = 4'd5;
    localparam logic [3:0] ST_S_WRX = 4'd6;
    localparam logic [3:0] ST_S_WRY = 4'd7;
    localparam logic [3:0] ST_S_END = 4'd8;
    localparam logic [3:0] ST_D_RDX = 4'd9;
    localparam logic [3:0] ST_D_RDY = 4'd10;
    localparam logic [3:0] ST_D_WRX = 4'd11;
    localparam logic [3:0] ST_D_WRY = 4'd12;
    localparam logic [3:0] ST_D_KS  = 4'd13;
    localparam logic [3:0] ST_EMIT  = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.capture = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (!i_stat.is_data) begin
                    n_state = ST_KEY;
                end else if (i_stat.keyed) begin
                    n_state = ST_D_RDX;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_KEY: begin
                o_cmd.key_load = 1'b1;
                if (i_stat.last) begin
                    o_cmd.sch_start = 1'b1;
                    n_state         = ST_INIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.x_max) begin
                    n_state = ST_S_RDX;
                end
            end
            ST_S_RDX: begin
                o_cmd.rd_x = 1'b1;
                n_state    = ST_S_RDY;
            end
            ST_S_RDY: begin
                o_cmd.rd_y  = 1'b1;
                o_cmd.sched = 1'b1;
                n_state     = ST_S_WRX;
            end
            ST_S_WRX: begin
                o_cmd.wr_x = 1'b1;
                n_state    = ST_S_WRY;
            end
            ST_S_WRY: begin
                o_cmd.wr_y  = 1'b1;
                o_cmd.sched = 1'b1;
                n_state     = i_stat.x_max ? ST_S_END : ST_S_RDX;
            end
            ST_S_END: begin
                o_cmd.sch_done = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_D_RDX: begin
                o_cmd.rd_xn = 1'b1;
                n_state     = ST_D_RDY;
            end
            ST_D_RDY: begin
                o_cmd.rd_y = 1'b1;
                n_state    = ST_D_WRX;
            end
            ST_D_WRX: begin
                o_cmd.wr_x = 1'b1;
                n_state    = ST_D_WRY;
            end
            ST_D_WRY: begin
                o_cmd.wr_y = 1'b1;
                n_state    = ST_D_KS;
            end
            ST_D_KS: begin
                o_cmd.rd_ks = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/rc4_datapath.sv =====
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation and key memories, indices, key bookkeeping and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rc4_stream_cipher_assert.svh"

module rc4_datapath
    import rc4_pkg::*;
#(
    parameter int KEY_BYTES_MAX = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_in_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_unkeyed,
    output logic              o_out_last
);

    localparam int KAW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int KCW = $clog2(KEY_BYTES_MAX + 1);

    logic [BYTE_W-1:0] r_perm [PERM_DEPTH];
    logic [BYTE_W-1:0] r_key  [KEY_BYTES_MAX];
    logic [BYTE_W-1:0] r_perm_rdata;
    logic [BYTE_W-1:0] r_key_rdata;

    logic              r_in_kind;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic [BYTE_W-1:0] r_t;
    logic [BYTE_W-1:0] r_sy;

    logic [BYTE_W-1:0] r_x;
    logic [BYTE_W-1:0] n_x;
    logic [BYTE_W-1:0] r_y;
    logic [BYTE_W-1:0] n_y;
    logic [KAW-1:0]    r_kpos;
    logic [KAW-1:0]    n_kpos;
    logic [KCW-1:0]    r_key_count;
    logic [KCW-1:0]    n_key_count;
    logic              r_keyed;
    logic              n_keyed;
    logic              r_loading;
    logic              n_loading;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_unkeyed;
    logic              r_out_last;

    logic              perm_we;
    logic [BYTE_W-1:0] perm_waddr;
    logic [BYTE_W-1:0] perm_wdata;
    logic              perm_re;
    logic [BYTE_W-1:0] perm_raddr;
    logic [BYTE_W-1:0] y_next;
    logic [KCW-1:0]    eff_count;
    logic              key_room;
    logic              key_we;
    logic [KCW-1:0]    key_len;
    logic [KCW:0]      kpos_inc;
    logic              kpos_wrap;
    logic              out_free;

    assign y_next    = r_y + r_perm_rdata + (i_cmd.sched ? r_key_rdata : '0);
    assign eff_count = r_loading ? r_key_count : '0;
    assign key_room  = eff_count < KCW'(KEY_BYTES_MAX);
    assign key_we    = i_cmd.key_load && key_room;
    assign key_len   = (r_key_count == '0) ? KCW'(1) : r_key_count;
    assign kpos_inc  = (KCW + 1)'(r_kpos) + (KCW + 1)'(1);
    assign kpos_wrap = kpos_inc >= (KCW + 1)'(key_len);
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        perm_we    = i_cmd.init_wr || i_cmd.wr_x || i_cmd.wr_y;
        perm_waddr = i_cmd.wr_y ? r_y : r_x;
        if (i_cmd.init_wr) begin
            perm_wdata = r_x;
        end else if (i_cmd.wr_x) begin
            perm_wdata = r_perm_rdata;
        end else begin
            perm_wdata = r_t;
        end
        perm_re = i_cmd.rd_x || i_cmd.rd_xn || i_cmd.rd_y || i_cmd.rd_ks;
        if (i_cmd.rd_xn) begin
            perm_raddr = r_x + 8'd1;
        end else if (i_cmd.rd_y) begin
            perm_raddr = y_next;
        end else if (i_cmd.rd_ks) begin
            perm_raddr = r_sy + r_t;
        end else begin
            perm_raddr = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            r_perm[perm_waddr] <= perm_wdata;
        end
        if (perm_re) begin
            r_perm_rdata <= r_perm[perm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[eff_count[KAW-1:0]] <= r_in_byte;
        end
        if (i_cmd.rd_x) begin
            r_key_rdata <= r_key[r_kpos];
        end
    end

    always_comb begin
        n_x         = r_x;
        n_y         = r_y;
        n_kpos      = r_kpos;
        n_key_count = r_key_count;
        n_keyed     = r_keyed;
        n_loading   = r_loading;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.key_load) begin
            n_loading   = 1'b1;
            n_keyed     = r_loading ? r_keyed : 1'b0;
            n_key_count = key_room ? eff_count + KCW'(1) : eff_count;
        end
        if (i_cmd.sch_start) begin
            n_x    = '0;
            n_y    = '0;
            n_kpos = '0;
        end
        if (i_cmd.init_wr || i_cmd.rd_xn || (i_cmd.wr_y && i_cmd.sched)) begin
            n_x = r_x + 8'd1;
        end
        if (i_cmd.wr_y && i_cmd.sched) begin
            n_kpos = kpos_wrap ? '0 : kpos_inc[KAW-1:0];
        end
        if (i_cmd.rd_y) begin
            n_y = y_next;
        end
        if (i_cmd.sch_done) begin
            n_y       = '0;
            n_keyed   = 1'b1;
            n_loading = 1'b0;
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_kpos      <= '0;
            r_key_count <= '0;
            r_keyed     <= 1'b0;
            r_loading   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_x         <= n_x;
            r_y         <= n_y;
            r_kpos      <= n_kpos;
            r_key_count <= n_key_count;
            r_keyed     <= n_keyed;
            r_loading   <= n_loading;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && i_in_valid) begin
            r_in_kind <= i_in_kind;
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (i_cmd.rd_y) begin
            r_t <= r_perm_rdata;
        end
        if (i_cmd.wr_x) begin
            r_sy <= r_perm_rdata;
        end
        if (i_cmd.emit) begin
            r_out_byte    <= r_in_byte ^ (r_keyed ? r_perm_rdata : '0);
            r_out_unkeyed <= !r_keyed;
            r_out_last    <= r_in_last;
        end
    end

    assign o_stat.is_data  = (r_in_kind == CMD_DATA);
    assign o_stat.last     = r_in_last;
    assign o_stat.keyed    = r_keyed;
    assign o_stat.x_max    = (r_x == BYTE_MAX);
    assign o_stat.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_unkeyed = r_out_unkeyed;
    assign o_out_last    = r_out_last;

    `RC4_ASSERT_NOW(a_emit_slot, i_cmd.emit, out_free, "result loaded into a full output register")
    `RC4_ASSERT_NOW(a_sched_wrap, i_cmd.sch_done, r_x == '0, "schedule ended with x not wrapped")
    `RC4_ASSERT_NEXT(a_key_start, i_cmd.key_load && !r_loading, !r_keyed && r_loading,
        "new key did not clear keyed")
    `RC4_ASSERT_NEXT(a_sched_done, i_cmd.sch_done, r_keyed && r_y == '0 && !r_loading,
        "schedule end left indices or flags wrong")

endmodule

// ===== src/rc4_stream_cipher.sv =====
// Data byte, keyed: S[x+1] and S[y] are read and swapped, the keystream byte is read
// and the result loaded; one request in flight (RAM port). Unkeyed byte: passed through.
// Key byte: stored. Last key byte: 256 fill writes, 256 swap steps and 1 end step follow.
// Output register lets the next request in while a result waits for m_axis_tready.
// Synchronous active-low reset clears indices, key count, flags and output valid;
// permutation and key memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Key loading, key schedule and byte-wise keystream XOR on a stream interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_BYTES_MAX = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] byte_in
    input  logic              s_axis_tuser,   // [0] cmd
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] byte_out
    output logic              m_axis_tuser,   // [0] unkeyed
    output logic              m_axis_tlast
);

    t_cmd  w_cmd;
    t_stat w_stat;

    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rc4_datapath #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_valid    (s_axis_tvalid),
        .i_in_kind     (s_axis_tuser),
        .i_in_byte     (s_axis_tdata),
        .i_in_last     (s_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_byte    (m_axis_tdata),
        .o_out_unkeyed (m_axis_tuser),
        .o_out_last    (m_axis_tlast)
    );

    assign s_axis_tready = w_cmd.capture;

endmodule
